[hdl/tep_pkg.sv]
// Shared types and codes for the terminal escape parser.
package tep_pkg;

    localparam int CHAR_W  = 8;
    localparam int CMD_W   = 3;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 7;
    localparam int COLOR_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SCROLL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COLOR  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BEEP   = 3'd5;

    localparam logic [COLOR_W-1:0] COLOR_NORMAL  = 3'd1;
    localparam logic [COLOR_W-1:0] COLOR_OTHER   = 3'd3;
    localparam logic [COLOR_W-1:0] COLOR_INVERSE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CHAR_W-1:0]  glyph_code;
        logic [ROW_W-1:0]   draw_row;
        logic [COL_W-1:0]   draw_col;
        logic [COLOR_W-1:0] color_code;
        logic [ROW_W-1:0]   cursor_row_now;
        logic [COL_W-1:0]   cursor_col_now;
        logic               last;
    } result_t;

endpackage

[hdl/tep_if.sv]
// Handshake channel interfaces: input bytes, result items, configuration writes.
interface tep_char_if;
    logic                       valid;
    logic                       ready;
    logic [tep_pkg::CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tep_result_if;
    logic             valid;
    logic             ready;
    tep_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tep_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tep_pkg::CFG_IDX_W-1:0]  index;
    logic [tep_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/terminal_escape_parser.sv]
// Terminal escape parser top level: byte parser, cursor state and result queue.
//
// Each console byte is taken into an input register, decoded against the
// cursor and parser state, and its one or two result items go into a two-entry result
// queue that drives the result channel. A byte that gives one result can be taken every
// cycle while the result channel keeps taking items; a byte that gives two (a draw at the
// right edge that scrolls) waits for an empty queue and holds the single result port for
// both items. A byte's first result reaches the port from the input register via the queue.
// Configuration writes are taken at any time (ready is always high) and apply to
// bytes decoded afterwards; register 0 is screen_cols, register 1 is screen_rows.
module terminal_escape_parser
(
    input  logic          clk,
    input  logic          rst_n,
    tep_char_if.sink      chars,
    tep_result_if.source  results,
    tep_cfg_if.sink       cfg
);

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_CSI    = 3'd2;
    localparam logic [2:0] MODE_ROW    = 3'd3;
    localparam logic [2:0] MODE_COL    = 3'd4;

    localparam logic [7:0] CH_BEL   = 8'd7;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SUB   = 8'd26;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_PRINT = 8'd28;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_M     = 8'h6D;

    // configuration
    logic [7:0] cols_reg;
    logic [6:0] rows_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] char_reg;

    // parser state
    logic [2:0] mode_reg, mode_next;
    logic [5:0] row_reg, row_next;
    logic [6:0] col_reg, col_next;
    logic [7:0] fp_reg, fp_next;
    logic [7:0] sp_reg, sp_next;
    logic       sel_reg, sel_next;

    // result queue
    tep_pkg::result_t q0_reg, q0_next, q1_reg, q1_next;
    logic [1:0]       count_reg, count_next;

    tep_pkg::result_t r0, r1;
    logic             two;
    logic [7:0]       eff_cols;
    logic [6:0]       eff_rows;
    logic [7:0]       arg;
    logic [7:0]       digit;
    logic             pop;
    logic [1:0]       cnt_pop;
    logic             room;
    logic             proc_fire;

    assign eff_cols = (cols_reg == 8'd0) ? 8'd1 : ((cols_reg > 8'd128) ? 8'd128 : cols_reg);
    assign eff_rows = (rows_reg == 7'd0) ? 7'd1 : ((rows_reg > 7'd64) ? 7'd64 : rows_reg);
    assign arg      = char_reg - CH_SPACE;
    assign digit    = char_reg - CH_ZERO;

    always_comb
    begin
        mode_next = mode_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        fp_next   = fp_reg;
        sp_next   = sp_reg;
        sel_next  = sel_reg;
        two       = 1'b0;
        r0        = '0;
        r0.command = tep_pkg::CMD_NONE;
        case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_NORMAL;
                if (char_reg == CH_LBRK)
                begin
                    fp_next   = 8'd0;
                    sp_next   = 8'd0;
                    sel_next  = 1'b0;
                    mode_next = MODE_CSI;
                end
                else if (char_reg == CH_Y || char_reg == CH_EQ)
                begin
                    mode_next = MODE_ROW;
                end
                else if (char_reg == CH_SEMI)
                begin
                    row_next   = 6'd0;
                    col_next   = 7'd0;
                    r0.command = tep_pkg::CMD_CLEAR;
                end
            end
            MODE_CSI:
            begin
                if (char_reg >= CH_ZERO && char_reg <= CH_NINE)
                begin
                    // p*10 + d, wraps at 256
                    if (sel_reg)
                        sp_next = (sp_reg << 3) + (sp_reg << 1) + digit;
                    else
                        fp_next = (fp_reg << 3) + (fp_reg << 1) + digit;
                end
                else if (char_reg == CH_SEMI)
                begin
                    sel_next = 1'b1;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    if (char_reg == CH_H)
                    begin
                        row_next = (fp_reg >= {1'b0, eff_rows}) ? 6'd0 : fp_reg[5:0];
                        col_next = (sp_reg >= eff_cols) ? 7'd0 : sp_reg[6:0];
                    end
                    else if (char_reg == CH_J)
                    begin
                        if (fp_reg == 8'd2)
                            r0.command = tep_pkg::CMD_CLEAR;
                    end
                    else if (char_reg == CH_M)
                    begin
                        r0.command = tep_pkg::CMD_COLOR;
                        if (fp_reg == 8'd0)
                            r0.color_code = tep_pkg::COLOR_NORMAL;
                        else if (fp_reg == 8'd7)
                            r0.color_code = tep_pkg::COLOR_INVERSE;
                        else
                            r0.color_code = tep_pkg::COLOR_OTHER;
                    end
                end
            end
            MODE_ROW:
            begin
                fp_next   = (arg >= {1'b0, eff_rows}) ? 8'd0 : arg;
                mode_next = MODE_COL;
            end
            MODE_COL:
            begin
                col_next  = (arg >= eff_cols) ? 7'd0 : arg[6:0];
                row_next  = fp_reg[5:0];
                mode_next = MODE_NORMAL;
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                if (char_reg == CH_ESC)
                begin
                    mode_next = MODE_ESC;
                end
                else if (char_reg == CH_BEL)
                begin
                    r0.command = tep_pkg::CMD_BEEP;
                end
                else if (char_reg == CH_LF)
                begin
                    r0.command = tep_pkg::CMD_NONE;
                end
                else if (char_reg < CH_PRINT && char_reg == CH_BS)
                begin
                    if (col_reg != 7'd0)
                    begin
                        col_next = col_reg - 7'd1;
                    end
                    else if (row_reg != 6'd0)
                    begin
                        row_next = row_reg - 6'd1;
                        col_next = 7'(eff_cols - 8'd1);
                    end
                end
                else if (char_reg == CH_FF || char_reg == CH_SUB)
                begin
                    row_next   = 6'd0;
                    col_next   = 7'd0;
                    r0.command = tep_pkg::CMD_CLEAR;
                end
                else if (char_reg == CH_CR)
                begin
                    col_next = 7'd0;
                    if ({1'b0, row_reg} + 7'd1 >= eff_rows)
                        r0.command = tep_pkg::CMD_SCROLL;
                    else
                        row_next = row_reg + 6'd1;
                end
                else
                begin
                    r0.command  = tep_pkg::CMD_DRAW;
                    r0.glyph_code = char_reg;
                    r0.draw_row = row_reg;
                    r0.draw_col = col_reg;
                    if ({1'b0, col_reg} + 8'd1 >= eff_cols)
                    begin
                        col_next = 7'd0;
                        if ({1'b0, row_reg} + 7'd1 >= eff_rows)
                            two = 1'b1;
                        else
                            row_next = row_reg + 6'd1;
                    end
                    else
                    begin
                        col_next = col_reg + 7'd1;
                    end
                end
            end
        endcase
        r0.cursor_row_now = row_next;
        r0.cursor_col_now = col_next;
        r0.last           = !two;
        r1                = '0;
        r1.command        = tep_pkg::CMD_SCROLL;
        r1.cursor_row_now = row_next;
        r1.cursor_col_now = col_next;
        r1.last           = 1'b1;
    end

    assign pop       = results.valid && results.ready;
    assign cnt_pop   = count_reg - {1'b0, pop};
    assign room      = two ? (cnt_pop == 2'd0) : (cnt_pop != 2'd2);
    assign proc_fire = in_valid_reg && room;

    assign chars.ready   = !in_valid_reg || proc_fire;
    assign results.valid = (count_reg != 2'd0);
    assign results.data  = q0_reg;
    assign cfg.ready     = 1'b1;

    always_comb
    begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        count_next = cnt_pop;
        if (pop)
            q0_next = q1_reg;
        if (proc_fire)
        begin
            if (cnt_pop == 2'd0)
            begin
                q0_next = r0;
                q1_next = r1;
            end
            else
            begin
                q1_next = r0;
            end
            count_next = cnt_pop + (two ? 2'd2 : 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= 8'd64;
            rows_reg     <= 7'd25;
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_NORMAL;
            row_reg      <= 6'd0;
            col_reg      <= 7'd0;
            fp_reg       <= 8'd0;
            sp_reg       <= 8'd0;
            sel_reg      <= 1'b0;
            count_reg    <= 2'd0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    tep_pkg::CFG_SCREEN_COLS: cols_reg <= cfg.data;
                    tep_pkg::CFG_SCREEN_ROWS: rows_reg <= cfg.data[6:0];
                    default: ;
                endcase
            end
            if (chars.ready)
                in_valid_reg <= chars.valid;
            if (proc_fire)
            begin
                mode_reg <= mode_next;
                row_reg  <= row_next;
                col_reg  <= col_next;
                fp_reg   <= fp_next;
                sp_reg   <= sp_next;
                sel_reg  <= sel_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
            char_reg <= chars.char_code;
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue overfilled");

    a_not_last_is_draw: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.data.last |->
            results.data.command == tep_pkg::CMD_DRAW && count_reg == 2'd2)
        else $error("non-final result without its scroll behind it");

    a_scroll_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !results.data.last |=>
            results.valid && results.data.command == tep_pkg::CMD_SCROLL && results.data.last)
        else $error("scroll result missing after wrap draw");

    a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proc_fire |=> in_valid_reg && $stable(char_reg))
        else $error("pending item lost");

endmodule
